>>> rtl/core/socks_handshake_parser_macros.svh
// Assertion macros shared by the SOCKS handshake parser RTL.
`ifndef SOCKS_HANDSHAKE_PARSER_MACROS_SVH
`define SOCKS_HANDSHAKE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("socks_handshake_parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("socks_handshake_parser: next-cycle check failed");

`endif

>>> rtl/core/shp_pkg.sv
// Types and constants of the SOCKS handshake parser.
package shp_pkg;

    // Parser phases; codes above PH_DONE are never entered.
    typedef enum logic [3:0] {
        PH_VER      = 4'd0,
        PH_V4_HDR   = 4'd1,
        PH_V4_USER  = 4'd2,
        PH_V5_NMETH = 4'd3,
        PH_V5_METH  = 4'd4,
        PH_V5_REQ   = 4'd5,
        PH_V5_IPV4  = 4'd6,
        PH_V5_NLEN  = 4'd7,
        PH_V5_NAME  = 4'd8,
        PH_V5_PORT  = 4'd9,
        PH_DONE     = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        EV_METHOD = 3'd0,
        EV_IPV4   = 3'd1,
        EV_NAME   = 3'd2,
        EV_DOMAIN = 3'd3,
        EV_DENY   = 3'd4,
        EV_LINK   = 3'd5
    } res_event_t;

    typedef enum logic [2:0] {
        DR_VERSION     = 3'd0,
        DR_NOT_CONNECT = 3'd1,
        DR_SOCKS4A     = 3'd2,
        DR_NO_METHOD   = 3'd3,
        DR_BAD_ATYP    = 3'd4,
        DR_MALFORMED   = 3'd5
    } deny_reason_t;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 3;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int VER_W   = 3;
    localparam int CODE_W  = 3;

    localparam logic [BYTE_W-1:0] SOCKS_VER4     = 8'h04;
    localparam logic [BYTE_W-1:0] SOCKS_VER5     = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_CONNECT    = 8'h01;
    localparam logic [BYTE_W-1:0] ATYP_IPV4      = 8'h01;
    localparam logic [BYTE_W-1:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [BYTE_W-1:0] METHOD_NO_AUTH = 8'h00;
    localparam logic [BYTE_W-1:0] RSV_BYTE       = 8'h00;
    localparam logic [BYTE_W-1:0] NUL_BYTE       = 8'h00;

    localparam logic [VER_W-1:0] PROTO_V4 = 3'd4;
    localparam logic [VER_W-1:0] PROTO_V5 = 3'd5;

    // Byte counts of the fixed-length fields.
    localparam logic [COUNT_W-1:0] V4_HDR_LEN  = 3'd7;
    localparam logic [COUNT_W-1:0] V5_REQ_LEN  = 3'd4;
    localparam logic [COUNT_W-1:0] V5_ADDR_LEN = 3'd4;
    localparam logic [COUNT_W-1:0] V5_IPV4_LEN = 3'd6;
    localparam logic [COUNT_W-1:0] PORT_LEN    = 3'd2;
    localparam logic [COUNT_W-1:0] V4_PORT_END = 3'd2;

endpackage

>>> rtl/core/socks_handshake_parser.sv
// SOCKS 4/5 server handshake parser, top level.
// A result appears on the m_ side in the cycle after the word that causes it is accepted.
// Throughput: one word per cycle while s_ready is high, parsed in a single combinational pass into the result register.
// s_ready is high whenever the result register is empty or is being read in the same cycle.
// Reset (aresetn low, synchronous) returns the parser to waiting for the version byte
// and empties the result register.
module socks_handshake_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [shp_pkg::BYTE_W-1:0]    s_rx_byte,
    input  logic                          s_restart,
    input  logic                          s_link_error,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [shp_pkg::CODE_W-1:0]    m_event_res,
    output logic [shp_pkg::VER_W-1:0]     m_proto_version,
    output logic [shp_pkg::ADDR_W-1:0]    m_dest_ipv4,
    output logic [shp_pkg::PORT_W-1:0]    m_dest_port,
    output logic [shp_pkg::BYTE_W-1:0]    m_name_char,
    output logic [shp_pkg::CODE_W-1:0]    m_deny_reason
);
    import shp_pkg::*;

`include "socks_handshake_parser_macros.svh"

    // Parser state registers and their next values.
    phase_t               phase_reg, phase_next;
    logic                 is_v5_reg, is_v5_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]    meth_left_reg, meth_left_next;
    logic                 meth_ok_reg, meth_ok_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PORT_W-1:0]    port_reg, port_next;
    logic [BYTE_W-1:0]    name_left_reg, name_left_next;

    // Result register.
    logic                 m_valid_reg;
    res_event_t           event_reg;
    logic [VER_W-1:0]     proto_reg;
    logic [ADDR_W-1:0]    ipv4_reg;
    logic [PORT_W-1:0]    port_out_reg;
    logic [BYTE_W-1:0]    char_reg;
    deny_reason_t         reason_reg;

    // A word is taken whenever the result register can take what it causes.
    logic s_fire;
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // A restart clears the state before the word is parsed, so the parse step
    // works on these values rather than on the registers directly.
    phase_t               phase_cur;
    logic                 is_v5_cur;
    logic [COUNT_W-1:0]   count_cur;
    logic [BYTE_W-1:0]    meth_left_cur;
    logic                 meth_ok_cur;
    logic [ADDR_W-1:0]    addr_cur;
    logic [PORT_W-1:0]    port_cur;
    logic [BYTE_W-1:0]    name_left_cur;

    always_comb begin
        if (s_restart) begin
            phase_cur     = PH_VER;
            is_v5_cur     = 1'b0;
            count_cur     = '0;
            meth_left_cur = '0;
            meth_ok_cur   = 1'b0;
            addr_cur      = '0;
            port_cur      = '0;
            name_left_cur = '0;
        end else begin
            phase_cur     = phase_reg;
            is_v5_cur     = is_v5_reg;
            count_cur     = count_reg;
            meth_left_cur = meth_left_reg;
            meth_ok_cur   = meth_ok_reg;
            addr_cur      = addr_reg;
            port_cur      = port_reg;
            name_left_cur = name_left_reg;
        end
    end

    // Shared decode of the incoming byte against the current state.
    logic [COUNT_W-1:0]   count_inc;
    logic [ADDR_W-1:0]    addr_shift;
    logic [PORT_W-1:0]    port_shift;
    logic [BYTE_W-1:0]    meth_left_dec;
    logic [BYTE_W-1:0]    name_left_dec;
    logic                 meth_ok_upd;
    logic                 v4_cmd_ok;
    logic                 v4a_addr;
    logic                 live;
    logic [BYTE_W-1:0]    req_ver, req_cmd, req_rsv, req_atyp;

    assign count_inc     = count_cur + 3'd1;
    assign addr_shift    = {addr_cur[ADDR_W-BYTE_W-1:0], s_rx_byte};
    assign port_shift    = {port_cur[PORT_W-BYTE_W-1:0], s_rx_byte};
    assign meth_left_dec = meth_left_cur - 8'd1;
    assign name_left_dec = name_left_cur - 8'd1;
    assign meth_ok_upd   = meth_ok_cur || (s_rx_byte == METHOD_NO_AUTH);
    // The command byte is the first byte of the version 4 header.
    assign v4_cmd_ok     = (count_cur == '0) ? (s_rx_byte == CMD_CONNECT) : meth_ok_cur;
    // A 4A request carries 0.0.0.x with a nonzero last byte.
    assign v4a_addr      = (addr_cur[ADDR_W-1:BYTE_W] == '0) && (addr_cur[BYTE_W-1:0] != '0);
    // The version 5 request header gathers in the address register.
    assign req_ver       = addr_shift[31:24];
    assign req_cmd       = addr_shift[23:16];
    assign req_rsv       = addr_shift[15:8];
    assign req_atyp      = addr_shift[7:0];
    // Every phase code from PH_DONE up means the handshake has ended.
    assign live          = (phase_cur < PH_DONE);

    // Next-state logic.
    always_comb begin
        phase_next     = phase_cur;
        is_v5_next     = is_v5_cur;
        count_next     = count_cur;
        meth_left_next = meth_left_cur;
        meth_ok_next   = meth_ok_cur;
        addr_next      = addr_cur;
        port_next      = port_cur;
        name_left_next = name_left_cur;
        if (live && s_link_error) begin
            phase_next = PH_DONE;
        end else if (live) begin
            case (phase_cur)
                PH_VER: begin
                    count_next = '0;
                    if (s_rx_byte == SOCKS_VER4) begin
                        is_v5_next = 1'b0;
                        phase_next = PH_V4_HDR;
                    end else if (s_rx_byte == SOCKS_VER5) begin
                        is_v5_next = 1'b1;
                        phase_next = PH_V5_NMETH;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_V4_HDR: begin
                    if (count_cur == '0) begin
                        meth_ok_next = v4_cmd_ok;
                    end else if (count_cur <= V4_PORT_END) begin
                        port_next = port_shift;
                    end else begin
                        addr_next = addr_shift;
                    end
                    count_next = count_inc;
                    if (count_inc == V4_HDR_LEN) begin
                        count_next = '0;
                        phase_next = v4_cmd_ok ? PH_V4_USER : PH_DONE;
                    end
                end
                PH_V4_USER: begin
                    if (s_rx_byte == NUL_BYTE) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_V5_NMETH: begin
                    meth_left_next = s_rx_byte;
                    meth_ok_next   = 1'b0;
                    phase_next     = (s_rx_byte == '0) ? PH_DONE : PH_V5_METH;
                end
                PH_V5_METH: begin
                    meth_ok_next   = meth_ok_upd;
                    meth_left_next = meth_left_dec;
                    if (meth_left_dec == '0) begin
                        if (meth_ok_upd) begin
                            phase_next = PH_V5_REQ;
                            count_next = '0;
                            addr_next  = '0;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_V5_REQ: begin
                    addr_next  = addr_shift;
                    count_next = count_inc;
                    if (count_inc == V5_REQ_LEN) begin
                        count_next = '0;
                        addr_next  = '0;
                        if (req_ver != SOCKS_VER5 || req_rsv != RSV_BYTE ||
                                req_cmd != CMD_CONNECT) begin
                            phase_next = PH_DONE;
                        end else if (req_atyp == ATYP_IPV4) begin
                            phase_next = PH_V5_IPV4;
                        end else if (req_atyp == ATYP_DOMAIN) begin
                            phase_next = PH_V5_NLEN;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_V5_IPV4: begin
                    if (count_cur < V5_ADDR_LEN) begin
                        addr_next = addr_shift;
                    end else begin
                        port_next = port_shift;
                    end
                    count_next = count_inc;
                    if (count_inc == V5_IPV4_LEN) begin
                        phase_next = PH_DONE;
                    end
                end
                PH_V5_NLEN: begin
                    name_left_next = s_rx_byte;
                    count_next     = '0;
                    phase_next     = (s_rx_byte == '0) ? PH_V5_PORT : PH_V5_NAME;
                end
                PH_V5_NAME: begin
                    name_left_next = name_left_dec;
                    if (name_left_dec == '0) begin
                        phase_next = PH_V5_PORT;
                        count_next = '0;
                    end
                end
                PH_V5_PORT: begin
                    port_next  = port_shift;
                    count_next = count_inc;
                    if (count_inc == PORT_LEN) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = phase_cur;
                end
            endcase
        end
    end

    // Result logic: what the current word reports, if anything.
    logic                 res_valid;
    res_event_t           res_event;
    logic [ADDR_W-1:0]    res_ipv4;
    logic [PORT_W-1:0]    res_port;
    logic [BYTE_W-1:0]    res_char;
    deny_reason_t         res_reason;

    always_comb begin
        res_valid  = 1'b0;
        res_event  = EV_METHOD;
        res_ipv4   = '0;
        res_port   = '0;
        res_char   = '0;
        res_reason = DR_VERSION;
        if (live && s_link_error) begin
            res_valid = 1'b1;
            res_event = EV_LINK;
        end else if (live) begin
            case (phase_cur)
                PH_VER: begin
                    if (s_rx_byte != SOCKS_VER4 && s_rx_byte != SOCKS_VER5) begin
                        res_valid = 1'b1;
                        res_event = EV_DENY;
                    end
                end
                PH_V4_HDR: begin
                    if (count_inc == V4_HDR_LEN && !v4_cmd_ok) begin
                        res_valid  = 1'b1;
                        res_event  = EV_DENY;
                        res_reason = DR_NOT_CONNECT;
                    end
                end
                PH_V4_USER: begin
                    if (s_rx_byte == NUL_BYTE) begin
                        res_valid = 1'b1;
                        if (v4a_addr) begin
                            res_event  = EV_DENY;
                            res_reason = DR_SOCKS4A;
                        end else begin
                            res_event = EV_IPV4;
                            res_ipv4  = addr_cur;
                            res_port  = port_cur;
                        end
                    end
                end
                PH_V5_NMETH: begin
                    if (s_rx_byte == '0) begin
                        res_valid  = 1'b1;
                        res_event  = EV_DENY;
                        res_reason = DR_NO_METHOD;
                    end
                end
                PH_V5_METH: begin
                    if (meth_left_dec == '0) begin
                        res_valid = 1'b1;
                        if (!meth_ok_upd) begin
                            res_event  = EV_DENY;
                            res_reason = DR_NO_METHOD;
                        end
                    end
                end
                PH_V5_REQ: begin
                    if (count_inc == V5_REQ_LEN) begin
                        res_event = EV_DENY;
                        if (req_ver != SOCKS_VER5 || req_rsv != RSV_BYTE) begin
                            res_valid  = 1'b1;
                            res_reason = DR_MALFORMED;
                        end else if (req_cmd != CMD_CONNECT) begin
                            res_valid  = 1'b1;
                            res_reason = DR_NOT_CONNECT;
                        end else if (req_atyp != ATYP_IPV4 && req_atyp != ATYP_DOMAIN) begin
                            res_valid  = 1'b1;
                            res_reason = DR_BAD_ATYP;
                        end
                    end
                end
                PH_V5_IPV4: begin
                    // The last byte is the low port byte, so the address is complete.
                    if (count_inc == V5_IPV4_LEN) begin
                        res_valid = 1'b1;
                        res_event = EV_IPV4;
                        res_ipv4  = addr_cur;
                        res_port  = port_shift;
                    end
                end
                PH_V5_NAME: begin
                    res_valid = 1'b1;
                    res_event = EV_NAME;
                    res_char  = s_rx_byte;
                end
                PH_V5_PORT: begin
                    if (count_inc == PORT_LEN) begin
                        res_valid = 1'b1;
                        res_event = EV_DOMAIN;
                        res_port  = port_shift;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // State update on every accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_VER;
            is_v5_reg     <= 1'b0;
            count_reg     <= '0;
            meth_left_reg <= '0;
            meth_ok_reg   <= 1'b0;
            addr_reg      <= '0;
            port_reg      <= '0;
            name_left_reg <= '0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            is_v5_reg     <= is_v5_next;
            count_reg     <= count_next;
            meth_left_reg <= meth_left_next;
            meth_ok_reg   <= meth_ok_next;
            addr_reg      <= addr_next;
            port_reg      <= port_next;
            name_left_reg <= name_left_next;
        end
    end

    // Result register: loads when a word causes a result, empties when read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            event_reg    <= res_event;
            proto_reg    <= is_v5_cur ? PROTO_V5 : PROTO_V4;
            ipv4_reg     <= res_ipv4;
            port_out_reg <= res_port;
            char_reg     <= res_char;
            reason_reg   <= res_reason;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = event_reg;
    assign m_proto_version = proto_reg;
    assign m_dest_ipv4     = ipv4_reg;
    assign m_dest_port     = port_out_reg;
    assign m_name_char     = char_reg;
    assign m_deny_reason   = reason_reg;

    // Conditions watched by the checks below.
    logic done_hold;
    logic res_final;
    assign done_hold = (phase_reg == PH_DONE) && !s_restart;
    assign res_final = res_valid && (res_event == EV_DENY || res_event == EV_LINK ||
                                     res_event == EV_IPV4 || res_event == EV_DOMAIN);

    // Once the handshake has ended, nothing but a restart brings a result.
    `SHP_ASSERT_IMP(a_done_silent, aclk, aresetn, done_hold, !res_valid)
    // Final results close the handshake.
    `SHP_ASSERT_NEXT(a_final_closes, aclk, aresetn, s_fire && res_final, phase_reg == PH_DONE)
    // The address field is only filled for an IPv4 request.
    `SHP_ASSERT_IMP(a_ipv4_only, aclk, aresetn, m_valid_reg && (event_reg != EV_IPV4), ipv4_reg == '0)

endmodule
